>>> src/podi_pkg.sv
// Shared constants, types and arithmetic helpers for the planar odometry integrator.
`default_nettype none

package podi_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_MAX   = 24;
  localparam int CORDIC_ITER  = (CORDIC_STEPS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STEPS;
  localparam int STEP_W       = $clog2(CORDIC_MAX);

  localparam int CW        = 34;
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 25;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

  localparam logic [CFG_IDX_W-1:0] REG_VEL_FORWARD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_LATERAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_RATE    = 2'd2;

  localparam logic signed [15:0] VEL_FORWARD_RST = 16'sd26;
  localparam logic signed [15:0] VEL_LATERAL_RST = -16'sd26;
  localparam logic signed [23:0] YAW_RATE_RST    = 24'sd1043;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT_START,
    ST_ROT_WAIT,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_MUL_D,
    ST_MUL_E,
    ST_MUL_F,
    ST_MUL_G,
    ST_HEAD,
    ST_HALF_START,
    ST_HALF_WAIT,
    ST_EMIT
  } state_t;

  function automatic logic [29:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85137876;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
    logic signed [CW:0] sum;
    logic signed [CW-15:0] sh;
    logic signed [15:0] r;
    sum = (CW+1)'(v) + (CW+1)'(16384);
    sh  = sum[CW:15];
    if (sh > (CW-14)'(32767)) begin
      r = 16'sh7fff;
    end else if (sh < -(CW-14)'(32768)) begin
      r = -16'sh8000;
    end else begin
      r = sh[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      r = -32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/podi_in_if.sv
// Tick request channel carrying the elapsed time.
`default_nettype none

interface podi_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] elapsed_time;

  modport source (output valid, output elapsed_time, input ready);
  modport sink (input valid, input elapsed_time, output ready);
endinterface

`default_nettype wire

>>> src/podi_out_if.sv
// Pose result channel carrying position, heading and yaw quaternion.
`default_nettype none

interface podi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_x;
  logic signed [31:0] position_y;
  logic        [15:0] heading_angle;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;

  modport source (output valid, output position_x, output position_y,
                  output heading_angle, output quat_z, output quat_w, input ready);
  modport sink (input valid, input position_x, input position_y,
                input heading_angle, input quat_z, input quat_w, output ready);
endinterface

`default_nettype wire

>>> src/podi_cfg_if.sv
// Configuration write channel carrying a register index and write data.
`default_nettype none

interface podi_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/podi_mul.sv
// Shared registered signed multiplier.
`default_nettype none

module podi_mul
  import podi_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] op_a,
  input  logic signed [MUL_B_W-1:0] op_b,
  output logic signed [PROD_W-1:0]  prod
);

  logic signed [PROD_W-1:0] full;

  assign full = op_a * op_b;

  always_ff @(posedge clk) begin
    prod <= full;
  end

endmodule

`default_nettype wire

>>> src/podi_cordic.sv
// Rotation-mode CORDIC producing Q1.15 cosine and sine, one iteration per cycle.
`default_nettype none

module podi_cordic
  import podi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [15:0] cos_q15,
  output logic signed [15:0] sin_q15
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_ITER - 1);

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [CW-1:0] z;
  logic                 neg;
  logic                 busy;
  logic [STEP_W-1:0]    step;

  logic [31:0]          ang_off;
  logic                 fold;
  logic [31:0]          ang_f;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] tab;

  always_comb begin
    ang_off = angle - 32'h4000_0000;
    fold    = ~ang_off[31];
    ang_f   = fold ? {~angle[31], angle[30:0]} : angle;
    dx      = y >>> step;
    dy      = x >>> step;
    tab     = $signed(CW'(atan_entry(step)));
    cos_q15 = to_q15(neg ? -x : x);
    sin_q15 = to_q15(neg ? -y : y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x    <= CORDIC_X0;
        y    <= '0;
        z    <= CW'($signed(ang_f));
        neg  <= fold;
      end else if (busy) begin
        if (!z[CW-1]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - tab;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + tab;
        end
        step <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> src/planar_odometry_integrator.sv
// Top level of the planar dead-reckoning pose integrator with its sequencer.
//
//   Channel  Dir  Carries
//   tick     in   elapsed_time (Q8.16 s)
//   pose     out  position_x, position_y, heading_angle, quat_z, quat_w
//   cfg      in   index, data (vel_forward, vel_lateral, yaw_rate)
//
// From acceptance to the result register, one request makes two passes through the
// shared CORDIC and seven products on the shared multiplier. Reset is synchronous
// and clears the pose and restores the register defaults. A result waits in the
// output register; the next request is taken as soon as the sequencer is idle, and
// finishing stalls only if that register is full.
`default_nettype none

module planar_odometry_integrator
  import podi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  podi_in_if.sink     tick,
  podi_out_if.source  pose,
  podi_cfg_if.sink    cfg
);

  state_t state;
  state_t state_next;

  logic signed [15:0] vel_forward;
  logic signed [15:0] vel_lateral;
  logic signed [23:0] yaw_rate;
  logic signed [31:0] pos_x_acc;
  logic signed [31:0] pos_y_acc;
  logic [15:0]        heading_acc;
  logic [23:0]        dt;
  logic signed [31:0] prod_hold;
  logic signed [32:0] rx;
  logic signed [32:0] ry;
  logic               out_valid;

  logic               cor_start;
  logic [31:0]        cor_angle;
  logic               cor_done;
  logic signed [15:0] cor_cos;
  logic signed [15:0] cor_sin;

  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [PROD_W-1:0]  prod;

  logic signed [PROD_W-1:0]  rnd;
  logic signed [34:0]        dpos;
  logic signed [35:0]        psum_x;
  logic signed [35:0]        psum_y;
  logic [PROD_W-1:0]         hsum;
  logic signed [MUL_B_W-1:0] dt_op;
  logic                      out_free;

  podi_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (cor_angle),
    .done    (cor_done),
    .cos_q15 (cor_cos),
    .sin_q15 (cor_sin)
  );

  podi_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign cfg.ready  = 1'b1;
  assign tick.ready = (state == ST_IDLE);
  assign pose.valid = out_valid;
  assign out_free   = !out_valid || pose.ready;

  always_comb begin
    rnd    = prod + (PROD_W'(1) << 22);
    dpos   = $signed(rnd[PROD_W-1:23]);
    psum_x = 36'(pos_x_acc) + 36'(dpos);
    psum_y = 36'(pos_y_acc) + 36'(dpos);
    hsum   = prod + (PROD_W'(1) << 15);
    dt_op  = $signed({1'b0, dt});
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:       if (tick.valid) state_next = ST_ROT_START;
      ST_ROT_START:  state_next = ST_ROT_WAIT;
      ST_ROT_WAIT:   if (cor_done) state_next = ST_MUL_A;
      ST_MUL_A:      state_next = ST_MUL_B;
      ST_MUL_B:      state_next = ST_MUL_C;
      ST_MUL_C:      state_next = ST_MUL_D;
      ST_MUL_D:      state_next = ST_MUL_E;
      ST_MUL_E:      state_next = ST_MUL_F;
      ST_MUL_F:      state_next = ST_MUL_G;
      ST_MUL_G:      state_next = ST_HEAD;
      ST_HEAD:       state_next = ST_HALF_START;
      ST_HALF_START: state_next = ST_HALF_WAIT;
      ST_HALF_WAIT:  if (cor_done) state_next = ST_EMIT;
      ST_EMIT:       if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cor_start = 1'b0;
    cor_angle = {heading_acc, 16'h0000};
    op_a      = '0;
    op_b      = '0;
    case (state)
      ST_ROT_START: begin
        cor_start = 1'b1;
      end
      ST_HALF_START: begin
        cor_start = 1'b1;
        cor_angle = {1'b0, heading_acc, 15'h0000};
      end
      ST_MUL_A: begin
        op_a = MUL_A_W'(vel_forward);
        op_b = MUL_B_W'(cor_cos);
      end
      ST_MUL_B: begin
        op_a = MUL_A_W'(vel_lateral);
        op_b = MUL_B_W'(cor_sin);
      end
      ST_MUL_C: begin
        op_a = MUL_A_W'(vel_forward);
        op_b = MUL_B_W'(cor_sin);
      end
      ST_MUL_D: begin
        op_a = MUL_A_W'(vel_lateral);
        op_b = MUL_B_W'(cor_cos);
      end
      ST_MUL_E: begin
        op_a = rx;
        op_b = dt_op;
      end
      ST_MUL_F: begin
        op_a = ry;
        op_b = dt_op;
      end
      ST_MUL_G: begin
        op_a = MUL_A_W'(yaw_rate);
        op_b = dt_op;
      end
      default: begin
        cor_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      vel_forward <= VEL_FORWARD_RST;
      vel_lateral <= VEL_LATERAL_RST;
      yaw_rate    <= YAW_RATE_RST;
      pos_x_acc   <= '0;
      pos_y_acc   <= '0;
      heading_acc <= '0;
    end else begin
      state <= state_next;

      if (cfg.valid) begin
        case (cfg.index)
          REG_VEL_FORWARD: vel_forward <= $signed(cfg.data[15:0]);
          REG_VEL_LATERAL: vel_lateral <= $signed(cfg.data[15:0]);
          REG_YAW_RATE:    yaw_rate    <= $signed(cfg.data);
          default:         yaw_rate    <= yaw_rate;
        endcase
      end

      if (tick.valid && tick.ready) begin
        dt <= tick.elapsed_time;
      end

      case (state)
        ST_MUL_B: prod_hold <= $signed(prod[31:0]);
        ST_MUL_C: rx <= 33'(prod_hold) - 33'($signed(prod[31:0]));
        ST_MUL_D: prod_hold <= $signed(prod[31:0]);
        ST_MUL_E: ry <= 33'(prod_hold) + 33'($signed(prod[31:0]));
        ST_MUL_F: pos_x_acc <= sat32(psum_x);
        ST_MUL_G: pos_y_acc <= sat32(psum_y);
        ST_HEAD:  heading_acc <= heading_acc + hsum[31:16];
        default:  prod_hold <= prod_hold;
      endcase

      if (state == ST_EMIT && out_free) begin
        out_valid          <= 1'b1;
        pose.position_x    <= pos_x_acc;
        pose.position_y    <= pos_y_acc;
        pose.heading_angle <= heading_acc;
        pose.quat_z        <= cor_sin;
        pose.quat_w        <= cor_cos;
      end else if (pose.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/planar_odometry_integrator_tb.sv
// Self-checking testbench for the planar odometry integrator: pose prediction and scoreboard.

module planar_odometry_integrator_tb;
  import podi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned STALL_CYCLES = 600;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [15:0] heading;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } pose_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst;

  podi_in_if  tick_if ();
  podi_out_if pose_if ();
  podi_cfg_if cfg_if ();

  planar_odometry_integrator dut (
    .clk  (clk),
    .rst  (rst),
    .tick (tick_if),
    .pose (pose_if),
    .cfg  (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  int atan_turn [CORDIC_MAX] = '{
    536870912, 316933406, 167458907, 85137876, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic signed [15:0] cfg_fwd;
  logic signed [15:0] cfg_lat;
  logic signed [23:0] cfg_yaw;
  logic signed [31:0] est_x;
  logic signed [31:0] est_y;
  logic        [15:0] est_heading;

  pose_t pending_poses [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  logic        stall_request = 1'b0;
  int unsigned stall_left = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  int unsigned rx_phase = 0;

  function automatic longint q15_round(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void cordic_sincos(input logic [31:0] ang, output longint cos_q,
                                        output longint sin_q);
    logic [31:0] a;
    logic flip;
    longint x, y, z, dx, dy;
    int i;
    a = ang;
    flip = 1'b0;
    if ((a - 32'h4000_0000) < 32'h8000_0000) begin
      a = a - 32'h8000_0000;
      flip = 1'b1;
    end
    x = longint'(CORDIC_X0);
    y = 0;
    z = longint'($signed(a));
    for (i = 0; i < CORDIC_ITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(atan_turn[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(atan_turn[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cos_q = q15_round(x);
    sin_q = q15_round(y);
  endfunction

  function automatic pose_t integrate_tick(input logic [23:0] dt_bits);
    longint dt, vf, vl, wr, c, s, rx, ry, p;
    pose_t r;
    dt = {40'd0, dt_bits};
    vf = longint'(cfg_fwd);
    vl = longint'(cfg_lat);
    wr = longint'(cfg_yaw);
    cordic_sincos({est_heading, 16'h0000}, c, s);
    rx = vf * c - vl * s;
    ry = vf * s + vl * c;
    est_x = 32'(clamp32(longint'(est_x) + ((rx * dt + 4194304) >>> 23)));
    est_y = 32'(clamp32(longint'(est_y) + ((ry * dt + 4194304) >>> 23)));
    p = wr * dt + 32768;
    est_heading = est_heading + p[31:16];
    cordic_sincos({1'b0, est_heading, 15'h0000}, c, s);
    r.x = est_x;
    r.y = est_y;
    r.heading = est_heading;
    r.qz = s[15:0];
    r.qw = c[15:0];
    return r;
  endfunction

  task automatic check_field(input string field, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    pose_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else if (!rst && pose_if.valid && pose_if.ready) begin
      if (pending_poses.size() == 0) begin
        mismatches++;
        $display("%0t ns: pose result with no request pending, expected none, actual x=%0d",
                 $time, pose_if.position_x);
      end else begin
        want = pending_poses.pop_front();
        check_field("position_x", want.x, pose_if.position_x);
        check_field("position_y", want.y, pose_if.position_y);
        check_field("heading_angle", 32'(want.heading), 32'(pose_if.heading_angle));
        check_field("quat_z", 32'(want.qz), 32'(pose_if.quat_z));
        check_field("quat_w", 32'(want.qw), 32'(pose_if.quat_w));
      end
    end
  end

  always @(negedge clk) begin
    if (stall_request) begin
      stall_request = 1'b0;
      stall_left = STALL_CYCLES;
    end
    if (stall_left != 0) begin
      stall_left--;
      pose_if.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 256);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        RX_OPEN: pose_if.ready <= 1'b1;
        RX_COIN: pose_if.ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: pose_if.ready <= ($urandom_range(0, 7) == 0);
        default: pose_if.ready <= (rx_phase % 3 == 0);
      endcase
    end
  end

  task automatic send_tick(input logic [23:0] dt);
    tick_if.valid <= 1'b1;
    tick_if.elapsed_time <= dt;
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
    pending_poses.push_back(integrate_tick(dt));
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_VEL_FORWARD: cfg_fwd = data[15:0];
      REG_VEL_LATERAL: cfg_lat = data[15:0];
      REG_YAW_RATE: cfg_yaw = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_poses.size() != 0) @(negedge clk);
  endtask

  task automatic apply_config(input logic [15:0] fwd, input logic [15:0] lat,
                              input logic [23:0] yaw);
    logic [7:0] pad_fwd, pad_lat;
    logic [23:0] junk;
    pad_fwd = 8'($urandom());
    pad_lat = 8'($urandom());
    junk = 24'($urandom());
    wait_drained();
    write_reg(REG_VEL_FORWARD, {pad_fwd, fwd});
    write_reg(REG_UNUSED, junk);
    write_reg(REG_VEL_LATERAL, {pad_lat, lat});
    write_reg(REG_YAW_RATE, yaw);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [23:0] random_elapsed();
    logic [23:0] dt;
    case ($urandom_range(0, 9))
      0: dt = 24'h000000;
      1: dt = 24'hFFFFFF;
      2, 3: dt = 24'($urandom());
      default: dt = 24'($urandom_range(0, 24'h00FFFF));
    endcase
    return dt;
  endfunction

  function automatic logic [15:0] random_velocity();
    logic [15:0] v;
    case ($urandom_range(0, 5))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2: v = 16'($urandom());
      default: v = 16'($urandom_range(0, 8191) - 4096);
    endcase
    return v;
  endfunction

  function automatic logic [23:0] random_yaw();
    logic [23:0] w;
    case ($urandom_range(0, 5))
      0: w = 24'h7FFFFF;
      1: w = 24'h800000;
      2, 3: w = 24'($urandom());
      default: w = 24'($urandom_range(0, 400000) - 200000);
    endcase
    return w;
  endfunction

  task automatic send_stream(input int unsigned count);
    int unsigned left, burst;
    left = count;
    while (left != 0) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      if (burst > left) burst = left;
      repeat (burst) send_tick(random_elapsed());
      left -= burst;
      if ($urandom_range(0, 2) != 0) begin
        tick_if.valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(negedge clk);
      end
    end
    tick_if.valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_tick(24'h000000);
    send_tick(24'h000001);
    send_tick(24'hFFFFFF);
    send_tick(24'h010000);
    send_tick(24'h800000);
    tick_if.valid <= 1'b0;
  endtask

  task automatic test_register_extremes();
    apply_config(16'h7FFF, 16'h8000, 24'h7FFFFF);
    send_tick(24'hFFFFFF);
    send_tick(24'h000001);
    send_tick(24'h000000);
    tick_if.valid <= 1'b0;
    apply_config(16'h8000, 16'h7FFF, 24'h800000);
    repeat (3) send_tick(24'hFFFFFF);
    tick_if.valid <= 1'b0;
  endtask

  task automatic test_heading_wrap();
    logic [15:0] back;
    apply_config(16'h0100, 16'h0000, 24'h010000);
    back = 16'h0000 - est_heading;
    send_tick({8'h00, back});
    send_tick(24'h004000);
    send_tick(24'h004000);
    send_tick(24'h000001);
    send_tick(24'h003FFF);
    send_tick(24'h004000);
    send_tick(24'h00FFFF);
    tick_if.valid <= 1'b0;
  endtask

  task automatic test_output_backpressure();
    apply_config(random_velocity(), random_velocity(), random_yaw());
    @(posedge clk);
    stall_request = 1'b1;
    @(negedge clk);
    repeat (24) send_tick(random_elapsed());
    tick_if.valid <= 1'b0;
  endtask

  task automatic test_random_phases();
    int unsigned sent, phase_len;
    sent = 0;
    while (sent < 600) begin
      apply_config(random_velocity(), random_velocity(), random_yaw());
      phase_len = $urandom_range(40, 90);
      send_stream(phase_len);
      sent += phase_len;
    end
  endtask

  initial begin
    rst = 1'b1;
    tick_if.valid = 1'b0;
    tick_if.elapsed_time = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    pose_if.ready = 1'b0;
    cfg_fwd = VEL_FORWARD_RST;
    cfg_lat = VEL_LATERAL_RST;
    cfg_yaw = YAW_RATE_RST;
    est_x = '0;
    est_y = '0;
    est_heading = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_heading_wrap();
    test_output_backpressure();
    test_random_phases();
    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_poses.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
src/podi_pkg.sv
src/podi_in_if.sv
src/podi_out_if.sv
src/podi_cfg_if.sv
src/podi_mul.sv
src/podi_cordic.sv
src/planar_odometry_integrator.sv
tb/planar_odometry_integrator_tb.sv
